### hw/rtl/sbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbf_pkg;

    // Most results one item can cause: sync, sync, id, length, command, checksum
    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Input item kinds
    localparam logic [1:0] IN_TX_START = 2'd0;
    localparam logic [1:0] IN_TX_PARAM = 2'd1;
    localparam logic [1:0] IN_RX_BYTE  = 2'd2;
    localparam logic [1:0] IN_RX_END   = 2'd3;

    // Result item kinds
    localparam logic [1:0] OUT_TX_BYTE = 2'd0;
    localparam logic [1:0] OUT_RX_BYTE = 2'd1;
    localparam logic [1:0] OUT_STATUS  = 2'd2;

    // Reply status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BAD_SYNC = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_BAD_SUM  = 3'd4;
    localparam logic [2:0] ST_NO_REPLY = 3'd5;

    // Instructions that get a status reply
    localparam logic [7:0] CMD_PING  = 8'd1;
    localparam logic [7:0] CMD_READ  = 8'd2;
    localparam logic [7:0] CMD_WRITE = 8'd3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Results caused by one item, emitted in order
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic [1:0]                        kind;
        logic [2:0]                        status;
        logic [7:0]                        params;
        logic [MAX_RESULTS-1:0][7:0]       bytes;
    } t_result_list;

endpackage

`default_nettype wire

### hw/rtl/sbf_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sbf_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_take,
    input  wire logic [1:0]           i_kind,
    input  wire logic [7:0]           i_servo_id,
    input  wire logic [7:0]           i_command,
    input  wire logic [7:0]           i_param_count,
    input  wire logic [7:0]           i_data_byte,
    output sbf_pkg::t_result_list     o_list
);
    import sbf_pkg::*;

    logic [7:0] r_tx_sum, n_tx_sum;
    logic [7:0] r_tx_left, n_tx_left;
    logic       r_expects_reply, n_expects_reply;
    logic [8:0] r_rx_count, n_rx_count;
    logic       r_rx_sync_bad, n_rx_sync_bad;
    logic [7:0] r_rx_length, n_rx_length;
    logic [7:0] r_rx_sum, n_rx_sum;
    logic       r_rx_sum_match, n_rx_sum_match;

    logic [7:0] len_byte;
    logic [7:0] start_sum;
    logic [7:0] param_sum;
    logic [8:0] rx_end;
    logic [8:0] rx_next;

    assign len_byte  = i_param_count + 8'd2;
    assign start_sum = i_servo_id + len_byte + i_command;
    assign param_sum = r_tx_sum + i_data_byte;
    assign rx_end    = {1'b0, r_rx_length} + 9'd4;
    assign rx_next   = r_rx_count + 9'd1;

    // Build the result list and the next state for the held item
    always_comb begin
        n_tx_sum        = r_tx_sum;
        n_tx_left       = r_tx_left;
        n_expects_reply = r_expects_reply;
        n_rx_count      = r_rx_count;
        n_rx_sync_bad   = r_rx_sync_bad;
        n_rx_length     = r_rx_length;
        n_rx_sum        = r_rx_sum;
        n_rx_sum_match  = r_rx_sum_match;

        o_list        = '0;
        o_list.kind   = OUT_TX_BYTE;

        case (i_kind)
            IN_TX_START: begin
                o_list.bytes[0] = SYNC_BYTE;
                o_list.bytes[1] = SYNC_BYTE;
                o_list.bytes[2] = i_servo_id;
                o_list.bytes[3] = len_byte;
                o_list.bytes[4] = i_command;
                o_list.bytes[5] = ~start_sum;
                o_list.count    = (i_param_count == 8'd0) ? CNT_W'(6) : CNT_W'(5);
                n_tx_sum        = start_sum;
                n_tx_left       = i_param_count;
                n_expects_reply = (i_command == CMD_PING) || (i_command == CMD_READ) ||
                                  (i_command == CMD_WRITE);
                n_rx_count      = '0;
                n_rx_sync_bad   = 1'b0;
                n_rx_length     = '0;
                n_rx_sum        = '0;
                n_rx_sum_match  = 1'b0;
            end
            IN_TX_PARAM: begin
                // drop a parameter byte when nothing is pending
                if (r_tx_left != 8'd0) begin
                    o_list.bytes[0] = i_data_byte;
                    o_list.bytes[1] = ~param_sum;
                    o_list.count    = (r_tx_left == 8'd1) ? CNT_W'(2) : CNT_W'(1);
                    n_tx_sum        = param_sum;
                    n_tx_left       = r_tx_left - 8'd1;
                end
            end
            IN_RX_BYTE: begin
                o_list.kind = OUT_RX_BYTE;
                if (r_rx_count < 9'd2) begin
                    if (i_data_byte != SYNC_BYTE) begin
                        n_rx_sync_bad = 1'b1;
                    end
                    n_rx_count = rx_next;
                end else if (r_rx_count < 9'd4) begin
                    if (r_rx_count == 9'd3) begin
                        n_rx_length = i_data_byte;
                    end
                    n_rx_sum   = r_rx_sum + i_data_byte;
                    n_rx_count = rx_next;
                end else if (r_rx_count < rx_end) begin
                    if (rx_next < rx_end) begin
                        n_rx_sum        = r_rx_sum + i_data_byte;
                        o_list.bytes[0] = i_data_byte;
                        o_list.count    = CNT_W'(1);
                    end else begin
                        n_rx_sum_match = (~r_rx_sum == i_data_byte);
                    end
                    n_rx_count = rx_next;
                end
            end
            default: begin
                // receive end: report, state untouched
                o_list.kind  = OUT_STATUS;
                o_list.count = CNT_W'(1);
                if (!r_expects_reply) begin
                    o_list.status = ST_NO_REPLY;
                end else if (r_rx_count < 9'd6) begin
                    o_list.status = ST_SHORT;
                end else if (r_rx_sync_bad) begin
                    o_list.status = ST_BAD_SYNC;
                end else if (r_rx_count != rx_end) begin
                    o_list.status = ST_BAD_LEN;
                end else if (!r_rx_sum_match) begin
                    o_list.status = ST_BAD_SUM;
                end else begin
                    o_list.status = ST_OK;
                    o_list.params = r_rx_length - 8'd2;
                end
            end
        endcase
    end

    // Advance framer and checker state when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_sum        <= '0;
            r_tx_left       <= '0;
            r_expects_reply <= 1'b0;
            r_rx_count      <= '0;
            r_rx_sync_bad   <= 1'b0;
            r_rx_length     <= '0;
            r_rx_sum        <= '0;
            r_rx_sum_match  <= 1'b0;
        end else if (i_take) begin
            r_tx_sum        <= n_tx_sum;
            r_tx_left       <= n_tx_left;
            r_expects_reply <= n_expects_reply;
            r_rx_count      <= n_rx_count;
            r_rx_sync_bad   <= n_rx_sync_bad;
            r_rx_length     <= n_rx_length;
            r_rx_sum        <= n_rx_sum;
            r_rx_sum_match  <= n_rx_sum_match;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sbf_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module sbf_emit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire sbf_pkg::t_result_list i_list,
    output logic                      o_load_ok,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_out_kind,
    output logic [7:0]                o_out_byte,
    output logic [2:0]                o_reply_status,
    output logic [7:0]                o_reply_params,
    output logic                      o_last
);
    import sbf_pkg::*;

    t_result_list     r_list;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] last_pos;
    logic             fire;

    assign last_pos  = r_list.count - CNT_W'(1);
    assign o_last    = ({1'b0, r_idx} == {{(IDX_W + 1 - CNT_W){1'b0}}, last_pos});
    assign fire      = r_busy && !i_stall;
    assign o_load_ok = !r_busy || (fire && o_last);

    assign o_valid        = r_busy;
    assign o_out_kind     = r_list.kind;
    assign o_out_byte     = r_list.bytes[r_idx];
    assign o_reply_status = r_list.status;
    assign o_reply_params = r_list.params;

    // Hold the result list and step through it one item per accepted output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load && o_load_ok) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_list <= i_list;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/servo_bus_v1_framer_checker.sv
// Flow: an accepted item waits in the input register until the output stage can load it;
// its results then leave one per cycle unless i_stall holds them (up to six for a transmit
// start). Throughput: one item per cycle when each causes at most one result and i_stall
// is low; the result stage sets the pace, and items causing none also wait for it.
// Reset: synchronous active-low i_rst_n clears all framer and checker state and empties
// both stages.
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_v1_framer_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_servo_id,
    input  wire logic [7:0] i_command,
    input  wire logic [7:0] i_param_count,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_reply_status,
    output logic [7:0]      o_reply_params,
    output logic            o_last
);
    import sbf_pkg::*;

    logic         r_in_valid;
    logic [1:0]   r_kind;
    logic [7:0]   r_servo_id;
    logic [7:0]   r_command;
    logic [7:0]   r_param_count;
    logic [7:0]   r_data_byte;
    logic         load_ok;
    logic         take;
    logic         accept;
    t_result_list list;

    assign take    = r_in_valid && load_ok;
    assign o_stall = r_in_valid && !load_ok;
    assign accept  = i_valid && !o_stall;

    // Input register: refill as the held item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind        <= i_kind;
            r_servo_id    <= i_servo_id;
            r_command     <= i_command;
            r_param_count <= i_param_count;
            r_data_byte   <= i_data_byte;
        end
    end

    sbf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_kind        (r_kind),
        .i_servo_id    (r_servo_id),
        .i_command     (r_command),
        .i_param_count (r_param_count),
        .i_data_byte   (r_data_byte),
        .o_list        (list)
    );

    sbf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (take && (list.count != '0)),
        .i_list         (list),
        .o_load_ok      (load_ok),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_reply_status (o_reply_status),
        .o_reply_params (o_reply_params),
        .o_last         (o_last)
    );

    // Stall only while an item waits in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with empty input register");

    // Status and received bytes come one per item
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == OUT_STATUS || o_out_kind == OUT_RX_BYTE) |-> o_last)
        else $error("status or received byte not marked last");

    // Reply parameter count only with an ok status
    a_params_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_reply_status != ST_OK) |-> (o_reply_params == 8'd0))
        else $error("reply params set with non-ok status");

    // A result leaving as last with no item waiting empties the output stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last && !r_in_valid |=> !o_valid)
        else $error("output stage did not drain");

endmodule

`default_nettype wire
